/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, clocked on aclk, off during reset
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMP(label, ante, cons, msg)
`define ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

/* sv/tbpr_pkg.sv */
`timescale 1ns / 1ps

package tbpr_pkg;

    localparam int MEM_BYTES  = 8192;
    localparam int BANK_DEPTH = MEM_BYTES / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    // tile map starts at byte 0x1800, word 0xc00
    localparam logic [2:0] MAP_WORD_HI = 3'b110;

    localparam logic [7:0] PALETTE_RESET = 8'hFC;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_RENDER = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_SCROLL_X   = 2'd0,
        CFG_SCROLL_Y   = 2'd1,
        CFG_BG_PALETTE = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MAP,
        ST_TILE
    } state_t;

    function automatic logic [31:0] shade_rgba(input logic [1:0] shade);
        logic [31:0] rgba;
        case (shade)
            2'd0:    rgba = 32'hFFFFFFFF;
            2'd1:    rgba = 32'hAAAAAAFF;
            2'd2:    rgba = 32'h555555FF;
            default: rgba = 32'h000000FF;
        endcase
        return rgba;
    endfunction

endpackage

/* sv/tile_background_pixel_renderer_top.sv */
`timescale 1ns / 1ps
// channel | dir | tvalid/tready | tdata                                   | tuser
// s_      | in  | s_tvalid      | offset 13, wdata 8, line 8, col 8 (40b) | cmd 2
// m_      | out | m_tvalid      | read_data 8, shade 2, rgba 32 (48b)     | -
// cfg_    | in  | cfg_wr_en     | cfg_index 2, cfg_data 8                 | -
//
// write or unused command: done in the idle step; read: idle, then read step; render:
// idle, map and tile steps (map byte read, then tile data word read, each one pass
// through the registered video memory banks); after reset a clearing pass zeroes all
// 4096 words of both banks; no transaction is taken while it runs
// a result waiting on m_tready holds the block in its last step; one output register
// lets the next transaction in as soon as the result is loaded
`include "assert_macros.svh"

module tile_background_pixel_renderer_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [12:0] mem_offset, [20:13] write_data, [28:21] screen_line, [36:29] screen_col
    input  logic [tbpr_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] cmd
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] read_data, [9:8] shade, [41:10] color_rgba
    output logic [tbpr_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [1:0]                     cfg_index,
    input  logic [7:0]                     cfg_data
);

    localparam int AW = tbpr_pkg::BANK_AW;

    // even and odd byte banks
    logic [7:0] mem_even [0:tbpr_pkg::BANK_DEPTH-1];
    logic [7:0] mem_odd  [0:tbpr_pkg::BANK_DEPTH-1];
    logic [7:0] q_even_reg;
    logic [7:0] q_odd_reg;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          we_even;
    logic          we_odd;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    tbpr_pkg::state_t state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          sel_reg, sel_next;
    logic [2:0]    row_reg, row_next;
    logic [2:0]    bx_lo_reg, bx_lo_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [tbpr_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [7:0] scroll_x_reg;
    logic [7:0] scroll_y_reg;
    logic [7:0] bg_palette_reg;

    logic [12:0] in_offset;
    logic [7:0]  in_wdata;
    logic [7:0]  in_line;
    logic [7:0]  in_col;
    logic [7:0]  bg_y;
    logic [7:0]  bg_x;
    logic [7:0]  sel_byte;
    logic [2:0]  bit_sel;
    logic [1:0]  color_idx;
    logic [1:0]  shade;
    logic        out_free;

    assign in_offset = s_tdata[12:0];
    assign in_wdata  = s_tdata[20:13];
    assign in_line   = s_tdata[28:21];
    assign in_col    = s_tdata[36:29];

    assign bg_y = in_line + scroll_y_reg;
    assign bg_x = in_col + scroll_x_reg;

    assign sel_byte  = sel_reg ? q_odd_reg : q_even_reg;
    assign bit_sel   = ~bx_lo_reg;
    assign color_idx = {q_odd_reg[bit_sel], q_even_reg[bit_sel]};
    assign shade     = bg_palette_reg[{color_idx, 1'b0} +: 2];

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == tbpr_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (we_even) begin
            mem_even[wr_addr] <= wr_data;
        end
        if (we_odd) begin
            mem_odd[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            q_even_reg <= mem_even[rd_addr];
            q_odd_reg  <= mem_odd[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scroll_x_reg   <= '0;
            scroll_y_reg   <= '0;
            bg_palette_reg <= tbpr_pkg::PALETTE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tbpr_pkg::CFG_SCROLL_X:   scroll_x_reg   <= cfg_data;
                tbpr_pkg::CFG_SCROLL_Y:   scroll_y_reg   <= cfg_data;
                tbpr_pkg::CFG_BG_PALETTE: bg_palette_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tbpr_pkg::ST_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sel_reg     <= sel_next;
        row_reg     <= row_next;
        bx_lo_reg   <= bx_lo_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        sel_next      = sel_reg;
        row_next      = row_reg;
        bx_lo_next    = bx_lo_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        rd_en         = 1'b0;
        rd_addr       = in_offset[12:1];
        we_even       = 1'b0;
        we_odd        = 1'b0;
        wr_addr       = in_offset[12:1];
        wr_data       = in_wdata;

        unique case (state_reg)
            tbpr_pkg::ST_CLEAR: begin
                we_even      = 1'b1;
                we_odd       = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg) begin
                    state_next = tbpr_pkg::ST_IDLE;
                end
            end
            tbpr_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    case (s_tuser)
                        tbpr_pkg::CMD_WRITE: begin
                            we_even = !in_offset[0];
                            we_odd  = in_offset[0];
                        end
                        tbpr_pkg::CMD_READ: begin
                            rd_en      = 1'b1;
                            sel_next   = in_offset[0];
                            state_next = tbpr_pkg::ST_READ;
                        end
                        tbpr_pkg::CMD_RENDER: begin
                            rd_en      = 1'b1;
                            rd_addr    = {tbpr_pkg::MAP_WORD_HI, bg_y[7:3], bg_x[7:4]};
                            sel_next   = bg_x[3];
                            row_next   = bg_y[2:0];
                            bx_lo_next = bg_x[2:0];
                            state_next = tbpr_pkg::ST_MAP;
                        end
                        default: ;
                    endcase
                end
            end
            tbpr_pkg::ST_READ: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(tbpr_pkg::M_TDATA_W - 8){1'b0}}, sel_byte};
                    state_next    = tbpr_pkg::ST_IDLE;
                end
            end
            tbpr_pkg::ST_MAP: begin
                // tile data word: lo byte even bank, hi byte odd bank
                rd_en      = 1'b1;
                rd_addr    = {1'b0, sel_byte, row_reg};
                state_next = tbpr_pkg::ST_TILE;
            end
            tbpr_pkg::ST_TILE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0, tbpr_pkg::shade_rgba(shade), shade, 8'd0};
                    state_next    = tbpr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tbpr_pkg::ST_IDLE;
            end
        endcase
    end

    `ASSERT_IMP(a_no_take_in_clear, state_reg == tbpr_pkg::ST_CLEAR, !s_tready,
        "transaction taken during clearing pass")
    `ASSERT_NXT(a_read_goes_wait, s_tvalid && s_tready && s_tuser == tbpr_pkg::CMD_READ,
        state_reg == tbpr_pkg::ST_READ, "read transaction did not start memory read")
    `ASSERT_IMP(a_result_source, $rose(m_tvalid_reg),
        $past(state_reg) == tbpr_pkg::ST_READ || $past(state_reg) == tbpr_pkg::ST_TILE,
        "result loaded outside read or tile step")
    `ASSERT_IMP(a_result_fields, m_tvalid_reg,
        m_tdata_reg[7:0] == 8'd0 || m_tdata_reg[41:8] == 34'd0,
        "result mixes read byte and render fields")

endmodule
